[design/pwc_pkg.sv]
// Package for the pixel write combiner: widths, result kinds, state codes, control structs.
// Used by pwc_ctrl, pwc_dp and the top level; depends on nothing.
package pwc_pkg;

  localparam int unsigned Buffers      = 2;
  localparam int unsigned BufferPixels = 16;
  localparam int unsigned BufW         = (Buffers > 1) ? $clog2(Buffers) : 1;
  localparam int unsigned IdxW         = (BufferPixels > 1) ? $clog2(BufferPixels) : 1;
  localparam int unsigned CntW         = 5;
  localparam int unsigned RamDepth     = Buffers * BufferPixels;
  localparam int unsigned AddrW        = $clog2(RamDepth);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_SINGLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_HORIZ = 2'd1,
    DIR_VERT  = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_HDR,
    ST_RD,
    ST_DATA,
    ST_SINGLE
  } state_e;

  // status from datapath to controller
  typedef struct packed {
    logic empty;      // current buffer empty
    logic hit;        // current buffer takes the pixel
    logic tried_all;  // all usable buffers tried
    logic used_zero;  // no buffers in use
    logic is_flush;   // held request is a flush action
    logic fl_done;    // flush scan finished
    logic more_pix;   // more pixels left to read out
    logic end_here;   // buffer being read out gives the request's final result
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic store;      // write pixel into current buffer
    logic start_rd;   // start pixel readout of current buffer
    logic rd_next;    // step readout to the next pixel
    logic clear_adv;  // empty current buffer and advance ring
    logic fl_next;    // flush: next buffer
  } cmd_t;

  localparam int unsigned RegBufIdx = 0;
  localparam int unsigned RegFmtIdx = 1;

endpackage

[design/pwc_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module pwc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/pwc_ctrl.sv]
// Controller state machine for the pixel write combiner.
// Depends on pwc_pkg.
module pwc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_last_o,
  output pwc_pkg::kind_e   out_kind_o,
  input  pwc_pkg::status_t st_i,
  output pwc_pkg::cmd_t    cmd_o
);
  pwc_pkg::state_e state_q, state_d;
  logic            take;

  assign take = out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pwc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pwc_pkg::ST_DECIDE;
      end
      pwc_pkg::ST_DECIDE: begin
        if (st_i.is_flush) begin
          if (st_i.fl_done) state_d = pwc_pkg::ST_IDLE;
          else if (!st_i.empty) state_d = pwc_pkg::ST_HDR;
        end else if (st_i.used_zero || st_i.tried_all) begin
          state_d = pwc_pkg::ST_SINGLE;
        end else if (st_i.empty || st_i.hit) begin
          state_d = pwc_pkg::ST_IDLE;
        end else begin
          state_d = pwc_pkg::ST_HDR;
        end
      end
      pwc_pkg::ST_HDR: begin
        if (take) state_d = pwc_pkg::ST_RD;
      end
      pwc_pkg::ST_RD: state_d = pwc_pkg::ST_DATA;
      pwc_pkg::ST_DATA: begin
        if (take) state_d = st_i.more_pix ? pwc_pkg::ST_RD : pwc_pkg::ST_DECIDE;
      end
      pwc_pkg::ST_SINGLE: begin
        if (take) state_d = pwc_pkg::ST_IDLE;
      end
      default: state_d = pwc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    out_kind_o  = pwc_pkg::KIND_HEADER;
    unique case (state_q)
      pwc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      pwc_pkg::ST_DECIDE: begin
        if (st_i.is_flush) begin
          if (!st_i.fl_done && st_i.empty) cmd_o.fl_next = 1'b1;
        end else if (!st_i.used_zero && !st_i.tried_all && (st_i.empty || st_i.hit)) begin
          cmd_o.store = 1'b1;
        end
      end
      pwc_pkg::ST_HDR: begin
        out_valid_o = 1'b1;
        cmd_o.start_rd = take;
      end
      pwc_pkg::ST_RD: ;
      pwc_pkg::ST_DATA: begin
        out_valid_o = 1'b1;
        out_kind_o  = pwc_pkg::KIND_DATA;
        // last pixel of the final buffer that this request reads out
        out_last_o  = !st_i.more_pix && st_i.end_here;
        cmd_o.rd_next = take;
        if (take && !st_i.more_pix) begin
          if (st_i.is_flush) cmd_o.fl_next = 1'b1;
          else cmd_o.clear_adv = 1'b1;
        end
      end
      pwc_pkg::ST_SINGLE: begin
        out_valid_o = 1'b1;
        out_last_o  = 1'b1;
        out_kind_o  = pwc_pkg::KIND_SINGLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_rd_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pwc_pkg::ST_RD |=> state_q == pwc_pkg::ST_DATA)
    else $error("read not followed by data");
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == pwc_pkg::KIND_SINGLE) |-> out_last_o)
    else $error("single pixel without last");
endmodule

[design/pwc_dp.sv]
// Datapath: run buffer descriptors, pixel RAM, hit test and result fields.
// Depends on pwc_pkg and pwc_ram.
module pwc_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       buf_cfg_i,
  input  logic             fmt_i,
  input  logic             action_i,
  input  logic [8:0]       pixel_x_i,
  input  logic [8:0]       pixel_y_i,
  input  logic [23:0]      pixel_color_i,
  input  pwc_pkg::cmd_t    cmd_i,
  input  pwc_pkg::kind_e   kind_i,
  output pwc_pkg::status_t st_o,
  output logic [8:0]       start_x_o,
  output logic [8:0]       start_y_o,
  output logic [8:0]       end_x_o,
  output logic [8:0]       end_y_o,
  output logic [4:0]       run_length_o,
  output logic [23:0]      color_out_o
);
  logic [8:0]  ox_q [pwc_pkg::Buffers];
  logic [8:0]  oy_q [pwc_pkg::Buffers];
  logic [4:0]  cnt_q [pwc_pkg::Buffers];
  logic [1:0]  dir_q [pwc_pkg::Buffers];
  logic [pwc_pkg::BufW-1:0] cur_q;
  logic [1:0]  tries_q;
  logic        act_q;
  logic [8:0]  x_q, y_q;
  logic [23:0] col_q;
  logic [4:0]  ridx_q;
  logic [1:0]  used;

  logic [pwc_pkg::BufW-1:0] bsel;
  logic [8:0]  bx, by;
  logic [4:0]  bc;
  logic [1:0]  bd;
  logic        hh, vh, hit;
  logic [8:0]  dxw, dyw;
  logic [1:0]  ndir;
  logic [8:0]  idx;
  logic        we;
  logic [pwc_pkg::AddrW-1:0] waddr, raddr;
  logic [23:0] rdata;
  logic [pwc_pkg::BufW-1:0] nxt;
  logic [8:0]  nbx, nby;
  logic [4:0]  nbc;
  logic [1:0]  nbd;
  logic        nhh, nvh, nx_hit, nx_take;
  logic        later_empty;

  assign used = (buf_cfg_i > 2'(pwc_pkg::Buffers)) ? 2'(pwc_pkg::Buffers) : buf_cfg_i;

  // a flush scans buffers by its own count; the ring position is left alone
  assign bsel = act_q ? tries_q[pwc_pkg::BufW-1:0] : cur_q;

  assign bx = ox_q[bsel];
  assign by = oy_q[bsel];
  assign bc = cnt_q[bsel];
  assign bd = dir_q[bsel];
  assign dxw = x_q - bx;
  assign dyw = y_q - by;

  // hit test against the current run
  always_comb begin
    hh = (y_q == by) && (x_q >= bx) && ({1'b0, x_q} <= {1'b0, bx} + 10'(bc));
    vh = (x_q == bx) && (y_q >= by) && ({1'b0, y_q} <= {1'b0, by} + 10'(bc));
    hit = 1'b0;
    if (bc < 5'(pwc_pkg::BufferPixels)) begin
      case (bd)
        pwc_pkg::DIR_NONE:  hit = hh || vh;
        pwc_pkg::DIR_HORIZ: hit = hh;
        pwc_pkg::DIR_VERT:  hit = vh;
        default:            hit = 1'b0;
      endcase
    end
  end

  // would the next buffer in the ring take the pixel
  always_comb begin
    nbx = ox_q[nxt];
    nby = oy_q[nxt];
    nbc = cnt_q[nxt];
    nbd = dir_q[nxt];
    nhh = (y_q == nby) && (x_q >= nbx) && ({1'b0, x_q} <= {1'b0, nbx} + 10'(nbc));
    nvh = (x_q == nbx) && (y_q >= nby) && ({1'b0, y_q} <= {1'b0, nby} + 10'(nbc));
    nx_hit = 1'b0;
    if (nbc < 5'(pwc_pkg::BufferPixels)) begin
      case (nbd)
        pwc_pkg::DIR_NONE:  nx_hit = nhh || nvh;
        pwc_pkg::DIR_HORIZ: nx_hit = nhh;
        pwc_pkg::DIR_VERT:  nx_hit = nvh;
        default:            nx_hit = 1'b0;
      endcase
    end
    nx_take = (nbc == '0) || nx_hit;
  end

  // every used buffer after the one being flushed is empty
  always_comb begin
    later_empty = 1'b1;
    for (int b = 0; b < pwc_pkg::Buffers; b++) begin
      if ((b > int'(tries_q)) && (b < int'(used)) && (cnt_q[b] != '0)) later_empty = 1'b0;
    end
  end

  // direction and index for a store (empty buffer: origin is the pixel, idx 0)
  always_comb begin
    ndir = bd;
    if (bc == '0) ndir = pwc_pkg::DIR_NONE;
    else if (bd == pwc_pkg::DIR_NONE) begin
      if (x_q > bx) ndir = pwc_pkg::DIR_HORIZ;
      else if (y_q > by) ndir = pwc_pkg::DIR_VERT;
    end
    idx = '0;
    if (bc != '0) begin
      if (ndir == pwc_pkg::DIR_HORIZ) idx = dxw;
      else if (ndir == pwc_pkg::DIR_VERT) idx = dyw;
    end
  end

  assign we    = cmd_i.store && (idx < 9'(pwc_pkg::BufferPixels));
  assign waddr = pwc_pkg::AddrW'(32'(cur_q) * pwc_pkg::BufferPixels
                 + 32'(idx[pwc_pkg::IdxW-1:0]));
  assign raddr = pwc_pkg::AddrW'(32'(bsel) * pwc_pkg::BufferPixels
                 + 32'(ridx_q[pwc_pkg::IdxW-1:0]));
  assign nxt   = ((32'(cur_q) + 1) >= 32'(used)) ? '0 : pwc_pkg::BufW'(32'(cur_q) + 1);

  pwc_ram #(.Width(24), .Depth(pwc_pkg::RamDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(col_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // request capture, ring and descriptor updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < pwc_pkg::Buffers; b++) begin
        ox_q[b]  <= '0;
        oy_q[b]  <= '0;
        cnt_q[b] <= '0;
        dir_q[b] <= pwc_pkg::DIR_NONE;
      end
      cur_q   <= '0;
      tries_q <= '0;
      act_q   <= 1'b0;
      ridx_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        act_q   <= action_i;
        tries_q <= '0;
        if (32'(cur_q) >= pwc_pkg::Buffers) cur_q <= '0;
      end
      if (cmd_i.store) begin
        if (bc == '0) begin
          ox_q[cur_q] <= x_q;
          oy_q[cur_q] <= y_q;
        end
        dir_q[cur_q] <= ndir;
        if (we && (idx == 9'(bc))) cnt_q[cur_q] <= bc + 5'd1;
      end
      if (cmd_i.start_rd) ridx_q <= '0;
      if (cmd_i.rd_next) ridx_q <= ridx_q + 5'd1;
      if (cmd_i.clear_adv) begin
        cnt_q[cur_q] <= '0;
        dir_q[cur_q] <= pwc_pkg::DIR_NONE;
        cur_q        <= nxt;
        tries_q      <= tries_q + 2'd1;
      end
      if (cmd_i.fl_next) begin
        cnt_q[bsel] <= '0;
        dir_q[bsel] <= pwc_pkg::DIR_NONE;
        tries_q     <= tries_q + 2'd1;
      end
    end
  end

  // payload of the held request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= pixel_x_i;
      y_q   <= pixel_y_i;
      col_q <= fmt_i ? pixel_color_i : {8'h00, pixel_color_i[15:0]};
    end
  end

  // status
  always_comb begin
    st_o.empty     = (bc == '0);
    st_o.hit       = hit;
    st_o.tried_all = (tries_q >= used);
    st_o.used_zero = (used == '0);
    st_o.is_flush  = act_q;
    // the flush scan ends when every used buffer has been visited
    st_o.fl_done   = act_q && (tries_q >= used);
    st_o.more_pix  = (5'(ridx_q + 5'd1) < bc);
    // a write ends here when an untried buffer remains and the next buffer then takes the pixel
    st_o.end_here  = act_q ? later_empty
                   : ((({1'b0, tries_q} + 3'd1) < {1'b0, used}) && nx_take);
  end

  // result fields
  always_comb begin
    start_x_o    = '0;
    start_y_o    = '0;
    end_x_o      = '0;
    end_y_o      = '0;
    run_length_o = '0;
    color_out_o  = '0;
    case (kind_i)
      pwc_pkg::KIND_HEADER: begin
        start_x_o    = bx;
        start_y_o    = by;
        end_x_o      = (bd == pwc_pkg::DIR_HORIZ) ? bx + 9'(bc) - 9'd1 : bx;
        end_y_o      = (bd == pwc_pkg::DIR_VERT) ? by + 9'(bc) - 9'd1 : by;
        run_length_o = bc;
      end
      pwc_pkg::KIND_DATA: color_out_o = rdata;
      pwc_pkg::KIND_SINGLE: begin
        start_x_o   = x_q;
        start_y_o   = y_q;
        color_out_o = col_q;
      end
      default: ;
    endcase
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |=> cnt_q[$past(cur_q)] <= 5'(pwc_pkg::BufferPixels))
    else $error("run count beyond buffer size");
  a_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.store && cmd_i.clear_adv)) else $error("store and flush together");
  a_load_tries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> tries_q == '0) else $error("try count not cleared");
endmodule

[design/pixel_write_combiner.sv]
// Top level of the pixel write combiner: APB registers, controller, datapath.
// Depends on pwc_pkg, pwc_ctrl, pwc_dp, pwc_ram.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+------------------------------------
//  input    | in_valid_i / in_ready_o       | action, pixel_x/y, pixel_color
//  output   | out_valid_o / out_ready_i     | kind, start/end x/y, length, colour
//  config   | psel/penable/pwrite, pready   | paddr, pwdata, prdata
//
// A write that hits or fills an empty buffer passes through IDLE and DECIDE. A miss
// adds a header result, then per stored pixel a RAM read (RD) and a result (DATA),
// also for a full 16-pixel run, as the RAM read is registered. Reset is
// asynchronous and active low; input waits while results are stalled.
module pixel_write_combiner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [8:0]  pixel_x_i,
  input  logic [8:0]  pixel_y_i,
  input  logic [23:0] pixel_color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [8:0]  start_x_o,
  output logic [8:0]  start_y_o,
  output logic [8:0]  end_x_o,
  output logic [8:0]  end_y_o,
  output logic [4:0]  run_length_o,
  output logic [23:0] color_out_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [1:0]       buf_q;
  logic             fmt_q;
  pwc_pkg::status_t st;
  pwc_pkg::cmd_t    cmd;
  pwc_pkg::kind_e   kind;

  assign pready = 1'b1;
  assign kind_o = kind;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= 2'd2;
      fmt_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == 1'(pwc_pkg::RegFmtIdx)) fmt_q <= pwdata[0];
      else buf_q <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == 1'(pwc_pkg::RegFmtIdx)) prdata[0] = fmt_q;
    else prdata[1:0] = buf_q;
  end

  pwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_last_o (last_o),
    .out_kind_o (kind),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  pwc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .buf_cfg_i    (buf_q),
    .fmt_i        (fmt_q),
    .action_i     (action_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .pixel_color_i(pixel_color_i),
    .cmd_i        (cmd),
    .kind_i       (kind),
    .st_o         (st),
    .start_x_o    (start_x_o),
    .start_y_o    (start_y_o),
    .end_x_o      (end_x_o),
    .end_y_o      (end_y_o),
    .run_length_o (run_length_o),
    .color_out_o  (color_out_o)
  );
endmodule
